// ----- rtl/core/pccrop_pkg.sv -----
// Shared constants, types and helper functions for the point crop to polar scan core.
package pccrop_pkg;

    localparam int COORD_BITS   = 32;
    localparam int CORDIC_STEPS = 16;
    localparam int GUARD_BITS   = 16;

    localparam int COORD_PAD = 32 - COORD_BITS;

    // Rotator width: coordinate, guard bits and headroom for the CORDIC gain.
    localparam int CORD_W = 32 + GUARD_BITS + 4;
    localparam int ANG_W  = 34;
    localparam int STEP_W = $clog2(CORDIC_STEPS);

    // Range scaling: x >> 14 times 1/K in Q28, done as two half-width products.
    localparam int RANGE_PRE   = 14;
    localparam int SH_W        = CORD_W - RANGE_PRE;
    localparam int HALF_W      = (SH_W + 1) / 2;
    localparam int GAIN_W      = 28;
    localparam int PROD_W      = HALF_W + GAIN_W;
    localparam int SUM_W       = PROD_W + HALF_W + 1;
    localparam int RANGE_SHIFT = 30;

    localparam logic [GAIN_W-1:0] INV_GAIN_Q28 = GAIN_W'(163008219);
    localparam logic [SUM_W-1:0]  RANGE_ROUND  = SUM_W'(64'd1 << (RANGE_SHIFT - 1));

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = ANG_W'(64'sd1686629713);
    localparam logic signed [ANG_W-1:0] ANGLE_ROUND = ANG_W'(64'sd65536);
    localparam logic signed [ANG_W-1:0] ANGLE_LIMIT = ANG_W'(64'sd25736);
    localparam logic [ANG_W-1:0]        ONE_Q30     = ANG_W'(64'd1 << 30);
    localparam int                      ANGLE_SHIFT = 17;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam int CAP_W = 21;

    typedef enum logic [2:0] {
        CFG_AXIS_ENABLE = 3'd0,
        CFG_MIN_X       = 3'd1,
        CFG_MAX_X       = 3'd2,
        CFG_MIN_Y       = 3'd3,
        CFG_MAX_Y       = 3'd4,
        CFG_MIN_Z       = 3'd5,
        CFG_MAX_Z       = 3'd6,
        CFG_CAPACITY    = 3'd7
    } t_cfg_idx;

    // One classified point on its way to the polar unit.
    typedef struct packed {
        logic               kept;
        logic               stored;
        logic               calc;
        logic [31:0]        slot_index;
        logic [31:0]        survivor_total;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
    } t_job;

    // Take the low COORD_BITS bits as a two's complement value.
    function automatic logic signed [31:0] coord_sext(input logic [31:0] v);
        logic signed [31:0] t;
        t = $signed(v << COORD_PAD);
        return t >>> COORD_PAD;
    endfunction

    // Elementary angle atan(2^-i) in Q30.
    function automatic logic signed [ANG_W-1:0] atan_step(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] v;
        unique case (int'(i))
            0:       v = ANG_W'(64'sd843314857);
            1:       v = ANG_W'(64'sd497837829);
            2:       v = ANG_W'(64'sd263043837);
            3:       v = ANG_W'(64'sd133525159);
            4:       v = ANG_W'(64'sd67021687);
            5:       v = ANG_W'(64'sd33543516);
            6:       v = ANG_W'(64'sd16775851);
            7:       v = ANG_W'(64'sd8388437);
            8:       v = ANG_W'(64'sd4194283);
            9:       v = ANG_W'(64'sd2097149);
            10:      v = ANG_W'(64'sd1048576);
            default: v = $signed(ONE_Q30 >> i);
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/core/pccrop_ifs.sv -----
// Valid/ready channel interfaces for points in and polar results out.
interface pccrop_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               last_point;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output last_point, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input last_point, output ready);
endinterface

interface pccrop_result_if;
    logic               valid;
    logic               ready;
    logic               kept;
    logic               stored;
    logic [31:0]        slot_index;
    logic signed [15:0] scan_angle;
    logic [31:0]        scan_range;
    logic [31:0]        survivor_total;

    modport source (output valid, output kept, output stored, output slot_index,
                    output scan_angle, output scan_range, output survivor_total,
                    input ready);
    modport sink   (input valid, input kept, input stored, input slot_index,
                    input scan_angle, input scan_range, input survivor_total,
                    output ready);
endinterface

// ----- rtl/core/pccrop_front.sv -----
// Front end: configuration registers, crop test and survivor slot allocation.
module pccrop_front
    import pccrop_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data,
    pccrop_point_if.sink        i_pt,
    input  logic                i_full,
    output logic                o_push,
    output t_job                o_job
);

    logic [1:0]         r_axis_en;
    logic signed [31:0] r_min_x, r_max_x, r_min_y, r_max_y, r_min_z, r_max_z;
    logic [CAP_W-1:0]   r_cap;
    logic [31:0]        r_count, n_count;

    logic signed [31:0] px, py, pz;
    logic               keep, store, accept;
    logic [31:0]        count_inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis_en <= '0;
            r_min_x   <= 32'sh8000_0000;
            r_max_x   <= 32'sh7FFF_FFFF;
            r_min_y   <= 32'sh8000_0000;
            r_max_y   <= 32'sh7FFF_FFFF;
            r_min_z   <= 32'sh8000_0000;
            r_max_z   <= 32'sh7FFF_FFFF;
            r_cap     <= CAP_W'(1048576);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_AXIS_ENABLE: r_axis_en <= i_cfg_data[1:0];
                CFG_MIN_X:       r_min_x   <= $signed(i_cfg_data);
                CFG_MAX_X:       r_max_x   <= $signed(i_cfg_data);
                CFG_MIN_Y:       r_min_y   <= $signed(i_cfg_data);
                CFG_MAX_Y:       r_max_y   <= $signed(i_cfg_data);
                CFG_MIN_Z:       r_min_z   <= $signed(i_cfg_data);
                CFG_MAX_Z:       r_max_z   <= $signed(i_cfg_data);
                CFG_CAPACITY:    r_cap     <= i_cfg_data[CAP_W-1:0];
            endcase
        end
    end

    assign i_pt.ready = !i_full;
    assign accept     = i_pt.valid && !i_full;

    always_comb begin
        px = coord_sext(i_pt.point_x);
        py = coord_sext(i_pt.point_y);
        pz = coord_sext(i_pt.point_z);

        keep = (pz >= r_min_z) && (pz <= r_max_z)
            && (!r_axis_en[0] || ((px >= r_min_x) && (px <= r_max_x)))
            && (!r_axis_en[1] || ((py >= r_min_y) && (py <= r_max_y)));

        // Saturate rather than wrap once the count is full.
        count_inc = (keep && (r_count != COUNT_MAX)) ? r_count + 32'd1 : r_count;
        store     = keep && (r_count < 32'(r_cap));

        n_count = r_count;
        if (accept) begin
            n_count = i_pt.last_point ? '0 : count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_push = accept;

    always_comb begin
        o_job.kept           = keep;
        o_job.stored         = store;
        o_job.calc           = store && ((px != '0) || (py != '0));
        o_job.slot_index     = keep ? r_count : '0;
        o_job.survivor_total = count_inc;
        o_job.point_x        = px;
        o_job.point_y        = py;
    end

endmodule

// ----- rtl/core/pccrop_queue.sv -----
// Short job queue between the crop front end and the polar unit.
module pccrop_queue
    import pccrop_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, r_rd;
    logic [Q_PTR_W:0]   r_fill;

    assign o_full  = (r_fill == (Q_PTR_W + 1)'(Q_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= '0;
            r_rd   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_fill <= r_fill + (Q_PTR_W + 1)'(i_push) - (Q_PTR_W + 1)'(i_pop);
        end
    end

endmodule

// ----- rtl/core/pccrop_polar.sv -----
// Back end: iterative CORDIC vectoring, range scaling and the result register.
module pccrop_polar
    import pccrop_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  t_job            i_job,
    output logic            o_pop,
    pccrop_result_if.source o_res
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_ITER = 5'b00010,
        S_MLO  = 5'b00100,
        S_MHI  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state                  r_state, n_state;
    logic signed [CORD_W-1:0] r_x, r_y;
    logic signed [ANG_W-1:0]  r_z;
    logic [STEP_W-1:0]        r_step;
    logic [PROD_W-1:0]        r_plo, r_phi;
    logic                     r_kept, r_stored, r_calc;
    logic [31:0]              r_slot, r_total;

    logic                     r_out_valid;
    logic                     r_o_kept, r_o_stored;
    logic [31:0]              r_o_slot, r_o_range, r_o_total;
    logic signed [15:0]       r_o_angle;

    logic signed [CORD_W-1:0] x0, y0, x_in, y_in, dx, dy;
    logic signed [ANG_W-1:0]  z_in;
    logic [SH_W-1:0]          xs;
    logic [HALF_W-1:0]        mul_a;
    logic [PROD_W-1:0]        mul_p;
    logic [SUM_W-1:0]         sum;
    logic [31:0]              range_q;
    logic signed [ANG_W-1:0]  ang_full;
    logic signed [15:0]       angle_q;
    logic                     out_free, last_step;

    assign out_free  = !r_out_valid || o_res.ready;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign last_step = (r_step == STEP_W'(CORDIC_STEPS - 1));

    // Turn a left-half vector by a quarter turn before the iterations.
    always_comb begin
        x0 = CORD_W'(i_job.point_x) <<< GUARD_BITS;
        y0 = CORD_W'(i_job.point_y) <<< GUARD_BITS;
        x_in = x0;
        y_in = y0;
        z_in = '0;
        if (x0 < 0) begin
            if (y0 >= 0) begin
                x_in = y0;
                y_in = -x0;
                z_in = HALF_PI_Q30;
            end else begin
                x_in = -y0;
                y_in = x0;
                z_in = -HALF_PI_Q30;
            end
        end
    end

    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;

    // x is never negative after the pre-turn, so the shifted value is unsigned.
    assign xs    = r_x[CORD_W-1:RANGE_PRE];
    assign mul_a = (r_state == S_MLO) ? xs[HALF_W-1:0] : HALF_W'(xs[SH_W-1:HALF_W]);
    assign mul_p = PROD_W'(mul_a) * PROD_W'(INV_GAIN_Q28);

    always_comb begin
        sum     = (SUM_W'(r_phi) << HALF_W) + SUM_W'(r_plo) + RANGE_ROUND;
        range_q = (|sum[SUM_W-1:RANGE_SHIFT+32]) ? 32'hFFFF_FFFF
                                                 : sum[RANGE_SHIFT+31:RANGE_SHIFT];
        ang_full = (r_z + ANGLE_ROUND) >>> ANGLE_SHIFT;
        priority if (ang_full > ANGLE_LIMIT) begin
            angle_q = 16'(ANGLE_LIMIT);
        end else if (ang_full < -ANGLE_LIMIT) begin
            angle_q = 16'(-ANGLE_LIMIT);
        end else begin
            angle_q = 16'(ang_full);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_empty) n_state = i_job.calc ? S_ITER : S_FIN;
            S_ITER: if (last_step) n_state = S_MLO;
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_FIN;
            S_FIN:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_x      <= x_in;
                r_y      <= y_in;
                r_z      <= z_in;
                r_step   <= '0;
                r_kept   <= i_job.kept;
                r_stored <= i_job.stored;
                r_calc   <= i_job.calc;
                r_slot   <= i_job.slot_index;
                r_total  <= i_job.survivor_total;
            end
            S_ITER: begin
                if (r_y >= 0) begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_step(r_step);
                end else begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_step(r_step);
                end
                r_step <= r_step + 1'b1;
            end
            S_MLO: r_plo <= mul_p;
            S_MHI: r_phi <= mul_p;
            S_FIN: ;
            default: ;
        endcase
    end

    // Result register: hold until taken, refill in the same cycle it drains.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_FIN) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FIN) && out_free) begin
            r_o_kept   <= r_kept;
            r_o_stored <= r_stored;
            r_o_slot   <= r_slot;
            r_o_total  <= r_total;
            r_o_angle  <= r_calc ? angle_q : '0;
            r_o_range  <= r_calc ? range_q : '0;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.kept           = r_o_kept;
    assign o_res.stored         = r_o_stored;
    assign o_res.slot_index     = r_o_slot;
    assign o_res.scan_angle     = r_o_angle;
    assign o_res.scan_range     = r_o_range;
    assign o_res.survivor_total = r_o_total;

endmodule

// ----- rtl/core/point_crop_to_polar_scan_core.sv -----
// Top level of the point crop to polar scan core.
//
//  channel   dir  handshake           payload
//  i_pt      in   valid / ready       point_x, point_y, point_z, last_point
//  o_res     out  valid / ready       kept, stored, slot_index, scan_angle,
//                                     scan_range, survivor_total
//  i_cfg_*   in   write enable only   i_cfg_idx, i_cfg_data
//
// A point is classified and given its slot in the cycle it is taken; a four-deep queue
// holds classified points for the polar unit. For a stored point off the origin that
// unit runs one CORDIC iteration per cycle, then the low and high halves on the shared
// half-width gain multiplier; any other point goes straight to the result stage.
// Synchronous active-low reset sets the default configuration and clears the survivor
// count, queue and result valid flag. The result register holds a transaction until
// it is taken while the front end keeps taking points until the queue is full.
module point_crop_to_polar_scan_core
    import pccrop_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [2:0]      i_cfg_idx,
    input  logic [31:0]     i_cfg_data,
    pccrop_point_if.sink    i_pt,
    pccrop_result_if.source o_res
);

    logic w_push, w_full, w_pop, w_empty;
    t_job w_front_job, w_head_job;

    pccrop_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pt       (i_pt),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    pccrop_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_head_job)
    );

    pccrop_polar u_polar (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (w_empty),
        .i_job   (w_head_job),
        .o_pop   (w_pop),
        .o_res   (o_res)
    );

    a_stored_is_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.stored) |-> o_res.kept)
        else $error("stored result that was not kept");

    a_unstored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.stored) |-> (o_res.scan_angle == '0 && o_res.scan_range == '0))
        else $error("polar fields set on an unstored result");

    a_dropped_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.kept) |-> (o_res.slot_index == '0))
        else $error("dropped point carries a slot");

    a_kept_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.kept) |-> (o_res.survivor_total != '0))
        else $error("kept point missing from survivor total");

endmodule

// ----- test/point_crop_to_polar_scan_checker.sv -----
// Checker for the point crop core: predicts every result transaction and compares it.
`timescale 1ns / 100ps
module point_crop_to_polar_scan_checker
    import pccrop_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    pccrop_point_if     i_pt,
    pccrop_result_if    i_res,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked
);

    localparam longint QUARTER_TURN_Q30 = 64'sd1686629713;
    localparam longint ANGLE_CLAMP      = 64'sd25736;
    localparam longint UNIT_GAIN_Q28    = 64'sd163008219;

    localparam longint ATAN_Q30 [0:10] = '{
        64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159, 64'sd67021687,
        64'sd33543516, 64'sd16775851, 64'sd8388437, 64'sd4194283, 64'sd2097149,
        64'sd1048576
    };

    typedef struct packed {
        logic        kept;
        logic        stored;
        logic [31:0] slot_index;
        logic [15:0] scan_angle;
        logic [31:0] scan_range;
        logic [31:0] survivor_total;
    } t_scan_result;

    // Shadow of the configuration and of the survivor counter
    logic [1:0]         crop_enable;
    logic signed [31:0] x_lo, x_hi, y_lo, y_hi, z_lo, z_hi;
    logic [20:0]        capacity;
    logic [31:0]        survivors;

    t_scan_result scan_results_due [$];
    int           mismatches = 0;
    int           due_count  = 0;
    int           results_seen = 0;

    assign o_errors  = mismatches;
    assign o_pending = due_count;
    assign o_checked = results_seen;

    function automatic longint rot_angle(input int i);
        if (i <= 10)
            return ATAN_Q30[i];
        return (longint'(1) <<< 30) >>> i;
    endfunction

    // Vectoring CORDIC: angle in Q3.13, range in unsigned Q16.16
    function automatic void polar_of(input longint px, input longint py,
                                     output logic [15:0] ang, output logic [31:0] rng);
        longint            vx, vy, acc, dx, dy, t, a;
        longint unsigned   ux, prod, r;
        int                i;
        ang = '0;
        rng = '0;
        if (px == 0 && py == 0)
            return;
        vx  = px <<< 16;
        vy  = py <<< 16;
        acc = 0;
        // turn the left half-plane onto the right one first
        if (vx < 0) begin
            t = vx;
            if (vy >= 0) begin
                vx  = vy;
                vy  = -t;
                acc = QUARTER_TURN_Q30;
            end else begin
                vx  = -vy;
                vy  = t;
                acc = -QUARTER_TURN_Q30;
            end
        end
        for (i = 0; i < CORDIC_STEPS; i++) begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0) begin
                vx  = vx + dx;
                vy  = vy - dy;
                acc = acc + rot_angle(i);
            end else begin
                vx  = vx - dx;
                vy  = vy + dy;
                acc = acc - rot_angle(i);
            end
        end
        a = (acc + 64'sd65536) >>> 17;
        if (a > ANGLE_CLAMP)
            a = ANGLE_CLAMP;
        if (a < -ANGLE_CLAMP)
            a = -ANGLE_CLAMP;
        ang  = a[15:0];
        ux   = vx;
        prod = (ux >> 14) * longint'(UNIT_GAIN_Q28);
        r    = (prod + (64'd1 << 29)) >> 30;
        if (r > 64'hFFFF_FFFF)
            r = 64'hFFFF_FFFF;
        rng = r[31:0];
    endfunction

    // Crop one point, hand out its slot and advance the survivor counter
    function automatic t_scan_result classify_point(input logic signed [31:0] px, py, pz,
                                                    input logic last);
        t_scan_result r;
        logic         keep;
        logic [15:0]  ang;
        logic [31:0]  rng;
        r    = '0;
        keep = 1'b1;
        if (crop_enable[0] && (px < x_lo || px > x_hi))
            keep = 1'b0;
        if (crop_enable[1] && (py < y_lo || py > y_hi))
            keep = 1'b0;
        if (pz < z_lo || pz > z_hi)
            keep = 1'b0;
        if (keep) begin
            r.kept       = 1'b1;
            r.slot_index = survivors;
            if (survivors != COUNT_MAX)
                survivors = survivors + 32'd1;
            if (r.slot_index < 32'(capacity)) begin
                r.stored = 1'b1;
                polar_of(px, py, ang, rng);
                r.scan_angle = ang;
                r.scan_range = rng;
            end
        end
        r.survivor_total = survivors;
        if (last)
            survivors = '0;
        return r;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, field, want_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        t_scan_result want, got;
        if (!i_rst_n) begin
            crop_enable = '0;
            x_lo        = 32'sh8000_0000;
            x_hi        = 32'sh7FFF_FFFF;
            y_lo        = 32'sh8000_0000;
            y_hi        = 32'sh7FFF_FFFF;
            z_lo        = 32'sh8000_0000;
            z_hi        = 32'sh7FFF_FFFF;
            capacity    = 21'd1048576;
            survivors   = '0;
            scan_results_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_AXIS_ENABLE: crop_enable = i_cfg_data[1:0];
                    CFG_MIN_X:       x_lo        = i_cfg_data;
                    CFG_MAX_X:       x_hi        = i_cfg_data;
                    CFG_MIN_Y:       y_lo        = i_cfg_data;
                    CFG_MAX_Y:       y_hi        = i_cfg_data;
                    CFG_MIN_Z:       z_lo        = i_cfg_data;
                    CFG_MAX_Z:       z_hi        = i_cfg_data;
                    CFG_CAPACITY:    capacity    = i_cfg_data[20:0];
                    default: ;
                endcase
            end
            // retire the oldest expectation before adding this edge's point
            if (i_res.valid && i_res.ready) begin
                results_seen++;
                got.kept           = i_res.kept;
                got.stored         = i_res.stored;
                got.slot_index     = i_res.slot_index;
                got.scan_angle     = i_res.scan_angle;
                got.scan_range     = i_res.scan_range;
                got.survivor_total = i_res.survivor_total;
                if (scan_results_due.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transaction expected none, got %0h", $time, got);
                end else begin
                    want = scan_results_due.pop_front();
                    check_field("kept", 32'(want.kept), 32'(got.kept));
                    check_field("stored", 32'(want.stored), 32'(got.stored));
                    check_field("slot_index", want.slot_index, got.slot_index);
                    check_field("scan_angle", 32'(want.scan_angle), 32'(got.scan_angle));
                    check_field("scan_range", want.scan_range, got.scan_range);
                    check_field("survivor_total", want.survivor_total, got.survivor_total);
                end
            end
            if (i_pt.valid && i_pt.ready)
                scan_results_due.push_back(classify_point(i_pt.point_x, i_pt.point_y,
                                                          i_pt.point_z, i_pt.last_point));
        end
        due_count = scan_results_due.size();
    end

endmodule

// ----- test/point_crop_to_polar_scan_core_test.sv -----
// Top of the point crop core testbench: clock, reset, point and config stimulus, verdict.
`timescale 1ns / 100ps
module point_crop_to_polar_scan_core_test;
    import pccrop_pkg::*;

    localparam int                 POLAR_LATENCY = CORDIC_STEPS + 8;
    localparam int                 HOLD_CYCLES   = 300;
    localparam int                 M             = 65536;
    localparam logic signed [31:0] COORD_MIN     = 32'sh8000_0000;
    localparam logic signed [31:0] COORD_MAX     = 32'sh7FFF_FFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic [31:0] cfg_data;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    bit hold_request    = 1'b0;
    int points_sent     = 0;
    int settings_loaded = 0;
    int error_total;
    int due_total;
    int checked_total;

    pccrop_point_if  pt_ch ();
    pccrop_result_if res_ch ();

    point_crop_to_polar_scan_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_ch),
        .o_res      (res_ch)
    );

    point_crop_to_polar_scan_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_pt       (pt_ch),
        .i_res      (res_ch),
        .o_errors   (error_total),
        .o_pending  (due_total),
        .o_checked  (checked_total)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Called at a falling edge; returns at the falling edge after the transaction
    task automatic send_point(input logic signed [31:0] px, py, pz, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            pt_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pt_ch.valid      <= 1'b1;
        pt_ch.point_x    <= px;
        pt_ch.point_y    <= py;
        pt_ch.point_z    <= pz;
        pt_ch.last_point <= last;
        do @(posedge i_clk); while (!pt_ch.ready);
        @(negedge i_clk);
        points_sent++;
    endtask

    task automatic drain_results;
        pt_ch.valid <= 1'b0;
        while (due_total != 0) @(negedge i_clk);
        repeat (POLAR_LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [31:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge i_clk);
    endtask

    // Unused upper bits of the narrow registers carry random junk
    task automatic load_crop_setup(input logic [1:0] en,
                                   input logic signed [31:0] xl, xh, yl, yh, zl, zh,
                                   input logic [20:0] cap);
        drain_results();
        write_reg(CFG_AXIS_ENABLE, {30'($urandom), en});
        write_reg(CFG_MIN_X, xl);
        write_reg(CFG_MAX_X, xh);
        write_reg(CFG_MIN_Y, yl);
        write_reg(CFG_MAX_Y, yh);
        write_reg(CFG_MIN_Z, zl);
        write_reg(CFG_MAX_Z, zh);
        write_reg(CFG_CAPACITY, {11'($urandom), cap});
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    task automatic pick_band(input bit allow_empty, output logic signed [31:0] lo, hi);
        logic signed [31:0] a, b;
        a = $urandom;
        b = $urandom;
        case ($urandom_range(5))
            0: begin
                lo = COORD_MIN;
                hi = COORD_MAX;
            end
            2: begin
                lo = -$signed(32'($urandom_range(1, 1 << 22)));
                hi = $urandom_range(0, 1 << 22);
            end
            3: begin
                // inverted band keeps nothing when allow_empty is set
                lo = (allow_empty == (a < b)) ? b : a;
                hi = (allow_empty == (a < b)) ? a : b;
            end
            4: begin
                lo = a;
                hi = a;
            end
            5: begin
                lo = -$signed(32'($urandom_range(0, 1 << 26)));
                hi = $urandom_range(1, 1 << 26);
            end
            default: begin
                lo = (a < b) ? a : b;
                hi = (a < b) ? b : a;
            end
        endcase
    endtask

    // Bias coordinates onto the band edges and into the band
    function automatic logic signed [31:0] pick_coord(input logic signed [31:0] lo, hi);
        logic signed [31:0] r32;
        longint             span;
        longint             v;
        r32 = $urandom;
        case ($urandom_range(9))
            0, 1: v = r32;
            2:    v = lo;
            3:    v = hi;
            4:    v = longint'(lo) - 1;
            5:    v = longint'(hi) + 1;
            6:    v = longint'($urandom_range(0, 4095)) - 2048;
            7:    v = 0;
            default: begin
                if (lo <= hi) begin
                    span = longint'(hi) - longint'(lo) + 1;
                    v    = longint'(lo) + (longint'({$urandom, $urandom} >> 1) % span);
                end else begin
                    v = r32;
                end
            end
        endcase
        return v[31:0];
    endfunction

    initial begin
        logic signed [31:0] xl, xh, yl, yh, zl, zh;
        logic [20:0]        cap;
        logic [1:0]         en;
        int                 setting;
        int                 n;

        i_rst_n          = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        pt_ch.valid      = 1'b0;
        pt_ch.point_x    = '0;
        pt_ch.point_y    = '0;
        pt_ch.point_z    = '0;
        pt_ch.last_point = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 13;
        recv_idle_pct = 54;

        // Reset settings: every point kept and stored
        send_point(0, 0, 0, 1'b0);
        send_point(COORD_MAX, COORD_MAX, 0, 1'b0);
        send_point(COORD_MIN, COORD_MIN, COORD_MAX, 1'b0);
        send_point(COORD_MIN, 0, COORD_MIN, 1'b0);
        send_point(COORD_MIN, -1, 0, 1'b0);
        send_point(0, COORD_MIN, 0, 1'b0);
        send_point(0, COORD_MAX, 0, 1'b0);
        send_point(COORD_MAX, COORD_MIN, 0, 1'b0);
        send_point(COORD_MIN, COORD_MAX, 0, 1'b0);
        send_point(1, 0, 0, 1'b0);
        send_point(-1, 0, 0, 1'b1);
        send_point(M, M, 0, 1'b0);

        // Tight box, three slots: edges, one outside on each axis, overflow
        load_crop_setup(2'd3, -10 * M, 10 * M, -5 * M, 5 * M, -M, 2 * M, 21'd3);
        send_point(-10 * M, 5 * M, -M, 1'b0);
        send_point(10 * M, -5 * M, 2 * M, 1'b0);
        send_point(10 * M + 1, 0, 0, 1'b0);
        send_point(0, -5 * M - 1, 0, 1'b0);
        send_point(0, 0, 2 * M + 1, 1'b0);
        send_point(3 * M, 4 * M, 0, 1'b0);
        send_point(3 * M, 4 * M, 0, 1'b0);
        send_point(1, 1, -M - 1, 1'b1);

        // No slots at all
        load_crop_setup(2'd0, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX,
                        COORD_MIN, COORD_MAX, 21'd0);
        send_point(5 * M, 5 * M, 0, 1'b0);
        send_point(0, 0, 0, 1'b1);

        // y band of a single value at the bottom, capacity beyond the nominal top
        load_crop_setup(2'd2, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN,
                        COORD_MIN, COORD_MAX, 21'h1F_FFFF);
        send_point(7, COORD_MIN, 0, 1'b0);
        send_point(7, COORD_MIN + 1, 0, 1'b1);

        for (setting = 0; setting < 9; setting++) begin
            send_idle_pct = (setting < 3) ? 13 : (setting < 6) ? 54 : 0;
            recv_idle_pct = (setting < 3) ? 54 : (setting < 6) ? 13 : 0;
            en = 2'($urandom_range(3));
            pick_band(1'b1, xl, xh);
            pick_band(1'b1, yl, yh);
            pick_band(1'b0, zl, zh);
            case ($urandom_range(5))
                0:       cap = '0;
                1:       cap = 21'd1048576;
                2:       cap = '1;
                3:       cap = 21'($urandom);
                default: cap = 21'($urandom_range(1, 24));
            endcase
            if (setting == 0) begin
                en = 2'd3;
                xl = COORD_MIN;
                xh = COORD_MAX;
                yl = COORD_MIN;
                yh = COORD_MAX;
                zl = COORD_MIN;
                zh = COORD_MAX;
            end
            load_crop_setup(en, xl, xh, yl, yh, zl, zh, cap);
            for (n = 0; n < 190; n++) begin
                if (setting == 1 && n == 40) begin
                    // hold the output off while points keep coming
                    pt_ch.valid <= 1'b0;
                    @(posedge i_clk);
                    hold_request = 1'b1;
                    @(negedge i_clk);
                end
                if (setting == 4 && n == 95)
                    drain_results();
                send_point(pick_coord(xl, xh), pick_coord(yl, yh), pick_coord(zl, zh),
                           $urandom_range(15) == 0);
            end
        end

        drain_results();
        $display("Checked %0d results from %0d points over %0d crop settings,", checked_total,
                 points_sent, settings_loaded);
        $display("with three idle mixes on both channels and one long output hold-off.");
        if (error_total == 0 && due_total == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/pccrop_pkg.sv
rtl/core/pccrop_ifs.sv
rtl/core/pccrop_front.sv
rtl/core/pccrop_queue.sv
rtl/core/pccrop_polar.sv
rtl/core/point_crop_to_polar_scan_core.sv
test/point_crop_to_polar_scan_checker.sv
test/point_crop_to_polar_scan_core_test.sv
